/* rtl/core/vfbc_pkg.sv */
package vfbc_pkg;

    localparam int CoordW  = 24;
    localparam int ExtW    = 23;
    localparam int ElemW   = 16;
    localparam int NormW   = ElemW + 1;
    localparam int RowW    = 4 * ElemW;
    localparam int NumRows = 4;
    localparam int NumPlanes = 6;
    localparam int CfgAddrW  = 2;
    localparam int InDataW   = 144;
    localparam int OutDataW  = 8;

    localparam int ProdW = NormW + CoordW;
    localparam int RadW  = NormW + ExtW;
    localparam int DW    = NormW + 8;
    localparam int DistW = ProdW + 3;
    localparam int RsumW = RadW + 2;
    localparam int DiffW = DistW + 1;

    localparam logic [CfgAddrW-1:0] REG_ROW0 = 2'd0;
    localparam logic [CfgAddrW-1:0] REG_ROW1 = 2'd1;
    localparam logic [CfgAddrW-1:0] REG_ROW2 = 2'd2;
    localparam logic [CfgAddrW-1:0] REG_ROW3 = 2'd3;

    localparam logic [RowW-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [RowW-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [RowW-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [RowW-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

    typedef struct packed {
        logic signed [CoordW-1:0] cx;
        logic signed [CoordW-1:0] cy;
        logic signed [CoordW-1:0] cz;
        logic        [ExtW-1:0]   ex;
        logic        [ExtW-1:0]   ey;
        logic        [ExtW-1:0]   ez;
    } box_t;

    typedef struct packed {
        logic signed [NormW-1:0] nx;
        logic signed [NormW-1:0] ny;
        logic signed [NormW-1:0] nz;
        logic signed [NormW-1:0] nw;
        logic        [NormW-1:0] ax;
        logic        [NormW-1:0] ay;
        logic        [NormW-1:0] az;
    } plane_t;

    typedef struct packed {
        logic ld2;
        logic ld3;
    } pctl_t;

endpackage

/* rtl/core/vfbc_plane.sv */
module vfbc_plane
    import vfbc_pkg::*;
(
    input  logic   clk,
    input  pctl_t  ctl,
    input  plane_t plane,
    input  box_t   box,
    output logic   pass
);

    logic signed [ProdW-1:0] px_reg, py_reg, pz_reg;
    logic signed [ProdW-1:0] px_next, py_next, pz_next;
    logic        [RadW-1:0]  rx_reg, ry_reg, rz_reg;
    logic        [RadW-1:0]  rx_next, ry_next, rz_next;
    logic signed [DW-1:0]    d_reg, d_next;
    logic signed [DistW-1:0] dist_reg, dist_next;
    logic        [RsumW-1:0] rad_reg, rad_next;
    logic signed [DiffW-1:0] diff;

    // products
    always_comb
    begin
        px_next = ProdW'(plane.nx * box.cx);
        py_next = ProdW'(plane.ny * box.cy);
        pz_next = ProdW'(plane.nz * box.cz);
        rx_next = RadW'(plane.ax * box.ex);
        ry_next = RadW'(plane.ay * box.ey);
        rz_next = RadW'(plane.az * box.ez);
        d_next  = {plane.nw, 8'd0};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld2)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            rz_reg <= rz_next;
            d_reg  <= d_next;
        end
    end

    // distance and radius sums
    always_comb
    begin
        dist_next = {{3{px_reg[ProdW-1]}}, px_reg}
                  + {{3{py_reg[ProdW-1]}}, py_reg}
                  + {{3{pz_reg[ProdW-1]}}, pz_reg}
                  + {{(DistW-DW){d_reg[DW-1]}}, d_reg};
        rad_next  = {2'b00, rx_reg} + {2'b00, ry_reg} + {2'b00, rz_reg};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld3)
        begin
            dist_reg <= dist_next;
            rad_reg  <= rad_next;
        end
    end

    assign diff = $signed({dist_reg[DistW-1], dist_reg}) - $signed({3'b000, rad_reg});
    assign pass = ~diff[DiffW-1];

endmodule

/* rtl/core/view_frustum_box_cull.sv */
// channel   dir  data                                              handshake
// s_axis    in   tdata[143:0]: center_x, center_y, center_z,       tvalid/tready
//                extent_x, extent_y, extent_z (low to high)
// m_axis    out  tdata[7:0]: inside_res                            tvalid/tready
// cfg       in   cfg_addr selects matrix_row0..3, cfg_data 64 bits  cfg_we
//
// one box per cycle sustained while m_axis_tready stays high
// stages: input register, 36 multipliers, plane sums, sign test and and-reduce
// planes are rebuilt from the matrix rows into registers every cycle
// rst_n clears the matrix rows to identity and empties the pipeline
// a stall at m_axis holds each stage only as far back as needed

module view_frustum_box_cull
    import vfbc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [RowW-1:0]     cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // center_x, center_y, center_z, extent_x, extent_y, extent_z, zero pad
    input  logic [InDataW-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // inside_res, zero pad
    output logic [OutDataW-1:0] m_axis_tdata
);

    logic [RowW-1:0] row_reg [NumRows];
    plane_t          plane_reg [NumPlanes];
    plane_t          plane_next [NumPlanes];

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;
    box_t box_reg;
    box_t box_in;
    pctl_t ctl;
    logic [NumPlanes-1:0] pass;
    logic inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[REG_ROW0] <= ROW0_RESET;
            row_reg[REG_ROW1] <= ROW1_RESET;
            row_reg[REG_ROW2] <= ROW2_RESET;
            row_reg[REG_ROW3] <= ROW3_RESET;
        end
        else if (cfg_we)
        begin
            row_reg[cfg_addr] <= cfg_data;
        end
    end

    // planes: row3 plus and minus rows 0..2
    always_comb
    begin
        logic signed [NormW-1:0] b [4];
        logic signed [NormW-1:0] s [4];
        logic signed [NormW-1:0] n [4];
        for (int p = 0; p < NumPlanes; p++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                b[k] = {row_reg[REG_ROW3][k*ElemW+ElemW-1], row_reg[REG_ROW3][k*ElemW +: ElemW]};
                s[k] = {row_reg[p/2][k*ElemW+ElemW-1], row_reg[p/2][k*ElemW +: ElemW]};
                n[k] = (p % 2 == 1) ? b[k] - s[k] : b[k] + s[k];
            end
            plane_next[p].nx = n[0];
            plane_next[p].ny = n[1];
            plane_next[p].nz = n[2];
            plane_next[p].nw = n[3];
            plane_next[p].ax = n[0][NormW-1] ? NormW'(-n[0]) : NormW'(n[0]);
            plane_next[p].ay = n[1][NormW-1] ? NormW'(-n[1]) : NormW'(n[1]);
            plane_next[p].az = n[2][NormW-1] ? NormW'(-n[2]) : NormW'(n[2]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NumPlanes; p++)
        begin
            plane_reg[p] <= plane_next[p];
        end
    end

    // stage control
    assign adv4 = ~v4_reg | m_axis_tready;
    assign adv3 = ~v3_reg | adv4;
    assign adv2 = ~v2_reg | adv3;
    assign adv1 = ~v1_reg | adv2;
    assign s_axis_tready = adv1;
    assign ctl.ld2 = adv2;
    assign ctl.ld3 = adv3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= s_axis_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    assign box_in.cx = s_axis_tdata[23:0];
    assign box_in.cy = s_axis_tdata[47:24];
    assign box_in.cz = s_axis_tdata[71:48];
    assign box_in.ex = s_axis_tdata[94:72];
    assign box_in.ey = s_axis_tdata[117:95];
    assign box_in.ez = s_axis_tdata[140:118];

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            box_reg <= box_in;
        end
    end

    for (genvar p = 0; p < NumPlanes; p++)
    begin : g_plane
        vfbc_plane u_plane (
            .clk   (clk),
            .ctl   (ctl),
            .plane (plane_reg[p]),
            .box   (box_reg),
            .pass  (pass[p])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            inside_reg <= &pass;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {{(OutDataW-1){1'b0}}, inside_reg};

endmodule
